### sv/berr_pkg.sv
// shared widths, codes and sizes for the binned event rate recorder
package berr_pkg;

    localparam int NUM_BINS   = 64;
    localparam int SLOT_W     = $clog2(NUM_BINS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int TIME_W     = 32;
    localparam int BIN_W      = 32;
    localparam int SUM_W      = 38;
    localparam int BSEC_W     = 16;
    localparam int NBIN_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int DCNT_W     = $clog2(TIME_W);

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BIN_SECONDS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = CFG_IDX_W'(1);

endpackage

### sv/berr_if.sv
// handshake channels of the binned event rate recorder: events, counts, register writes
interface berr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [berr_pkg::TIME_W-1:0] time_s;
    logic [berr_pkg::TIME_W-1:0] lookback_s;

    modport source (output valid, kind, time_s, lookback_s, input ready);
    modport sink   (input valid, kind, time_s, lookback_s, output ready);
endinterface

interface berr_out_if;
    logic                       valid;
    logic                       ready;
    logic [berr_pkg::SUM_W-1:0] tick_count;

    modport source (output valid, tick_count, input ready);
    modport sink   (input valid, tick_count, output ready);
endinterface

interface berr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [berr_pkg::CFG_IDX_W-1:0]  index;
    logic [berr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/binned_event_rate_recorder_core.sv
// binned event rate recorder: ring of time bins, one shared radix-2 divider under a sequencer
//
//  channel  dir  payload                        beat taken when
//  i_evt    in   kind, time_s, lookback_s       valid & ready, ready only while idle
//  o_cnt    out  tick_count (queries only)      valid & ready, held in an output register
//  i_cfg    in   index, data                    valid & ready, ready always high
//
// every division (bin number, slot in the ring) runs on one divider, one quotient bit a cycle.
// a tick into a bin already open bumps it, a tick too old for the ring is dropped, and a tick
// that opens a newer bin first clears the skipped bins; a query sums up to 64 bins, or none
// when the window is empty.
// reset is synchronous; the bins read as zero right after it through per-bin valid bits.
// a finished count waits in the output register; the sequencer stalls only if the previous
// count has not yet been taken.
module binned_event_rate_recorder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    berr_in_if.sink    i_evt,
    berr_out_if.source o_cnt,
    berr_cfg_if.sink   i_cfg
);
    import berr_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DLAST = 14'b00000000000010,
        S_DBIN  = 14'b00000000000100,
        S_DIFF  = 14'b00000000001000,
        S_PLAN  = 14'b00000000010000,
        S_DWALK = 14'b00000000100000,
        S_CLEAR = 14'b00000001000000,
        S_DSLOT = 14'b00000010000000,
        S_SET   = 14'b00000100000000,
        S_RD    = 14'b00001000000000,
        S_BUMP  = 14'b00010000000000,
        S_SUMRD = 14'b00100000000000,
        S_SUM   = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [BSEC_W-1:0] r_bin_sec;
    logic [NBIN_W-1:0] r_bins_use;

    // item and working registers
    logic              r_kind;
    logic [TIME_W-1:0] r_t, r_back, r_newest;
    logic [TIME_W-1:0] r_last, r_bin;
    logic [TIME_W:0]   r_diff;
    logic [CNT_W-1:0]  r_cnt;
    logic [SLOT_W-1:0] r_slot;
    logic              r_set, r_upd;
    logic [SUM_W-1:0]  r_sum, r_odata;
    logic              r_ov;

    // bin store
    logic [BIN_W-1:0]    mem [NUM_BINS];
    logic [NUM_BINS-1:0] r_vld;
    logic [BIN_W-1:0]    r_rd_data;
    logic                r_rd_vld;
    logic                mem_we;
    logic [BIN_W-1:0]    mem_wdata;

    // shared divider
    logic [TIME_W-1:0] r_dq;
    logic [BSEC_W-1:0] r_rem, r_dvs;
    logic [DCNT_W-1:0] r_dcnt;
    logic [BSEC_W:0]   rem_sh, rem_nx;
    logic              q_bit, div_done, div_go;
    logic [TIME_W-1:0] q_nx, div_a;
    logic [BSEC_W-1:0] div_b;

    logic              in_fire, out_load;
    logic [BSEC_W-1:0] w_now, n16;
    logic [NBIN_W-1:0] n_clamp;
    logic [CNT_W-1:0]  n_now, nm1, gap;
    logic [TIME_W:0]   ng;
    logic              diff_borrow, diff_zero, older_ok, span_small, gap_small;
    logic [SLOT_W-1:0] cnt_m1, slot_nx;
    logic [TIME_W-1:0] win_t;
    logic [BIN_W-1:0]  rd_val, rd_inc;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sum_sat;

    assign in_fire      = i_evt.valid && i_evt.ready;
    assign i_evt.ready  = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_cnt.valid  = r_ov;
    assign o_cnt.tick_count = r_odata;
    assign out_load     = (r_state == S_OUT) && (!r_ov || o_cnt.ready);

    // effective settings
    always_comb begin
        w_now = (r_bin_sec == '0) ? BSEC_W'(1) : r_bin_sec;
        if (r_bins_use < NBIN_W'(2)) begin
            n_clamp = NBIN_W'(2);
        end else if (int'(r_bins_use) > NUM_BINS) begin
            n_clamp = NBIN_W'(NUM_BINS);
        end else begin
            n_clamp = r_bins_use;
        end
        n_now = CNT_W'(n_clamp);
        nm1   = n_now - CNT_W'(1);
        n16   = BSEC_W'(n_now);
    end

    // divider step
    assign rem_sh   = {r_rem, r_dq[TIME_W-1]};
    assign q_bit    = (rem_sh >= {1'b0, r_dvs});
    assign rem_nx   = q_bit ? (rem_sh - {1'b0, r_dvs}) : rem_sh;
    assign q_nx     = {r_dq[TIME_W-2:0], q_bit};
    assign div_done = (r_dcnt == DCNT_W'(TIME_W - 1));

    // plan decisions on the bin distance
    assign diff_borrow = r_diff[TIME_W];
    assign diff_zero   = (r_diff == '0);
    assign older_ok    = !diff_borrow && (r_diff[TIME_W:CNT_W] == '0)
                         && (r_diff[CNT_W-1:0] < n_now);
    assign ng          = ~r_diff;
    assign gap_small   = (ng[TIME_W:CNT_W] == '0) && (ng[CNT_W-1:0] < n_now);
    assign gap         = gap_small ? ng[CNT_W-1:0] : n_now;
    assign span_small  = (r_diff[TIME_W:CNT_W] == '0) && (r_diff[CNT_W-1:0] < nm1);
    assign cnt_m1      = span_small ? r_diff[SLOT_W-1:0] : nm1[SLOT_W-1:0];
    assign win_t       = (r_back > r_t) ? '0 : (r_t - r_back);
    assign slot_nx     = ({1'b0, r_slot} == nm1) ? '0 : (r_slot + SLOT_W'(1));

    // bin arithmetic
    assign rd_val  = r_rd_vld ? r_rd_data : '0;
    assign rd_inc  = (&rd_val) ? rd_val : (rd_val + BIN_W'(1));
    assign sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(rd_val);
    assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = rd_inc;
        case (r_state)
            S_SET: begin
                mem_we    = 1'b1;
                mem_wdata = BIN_W'(1);
            end
            S_BUMP: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        div_go  = 1'b0;
        div_a   = r_bin;
        div_b   = n16;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_DLAST;
                    div_go  = 1'b1;
                    div_a   = r_newest;
                    div_b   = w_now;
                end
            end
            S_DLAST: begin
                if (div_done) begin
                    n_state = S_DBIN;
                    div_go  = 1'b1;
                    div_a   = (r_kind == KIND_TICK) ? r_t : win_t;
                    div_b   = w_now;
                end
            end
            S_DBIN: begin
                if (div_done) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = S_PLAN;
            end
            S_PLAN: begin
                if (r_kind == KIND_TICK) begin
                    if (diff_borrow) begin
                        // newer bin: find the first skipped slot
                        n_state = S_DWALK;
                        div_go  = 1'b1;
                        div_a   = r_last + TIME_W'(1);
                    end else if (diff_zero || older_ok) begin
                        n_state = S_DSLOT;
                        div_go  = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    if (diff_borrow) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DWALK;
                        div_go  = 1'b1;
                        div_a   = r_last - TIME_W'(cnt_m1);
                    end
                end
            end
            S_DWALK: begin
                if (div_done) begin
                    if (r_kind == KIND_QUERY) begin
                        n_state = S_SUMRD;
                    end else if (r_cnt == '0) begin
                        n_state = S_DSLOT;
                        div_go  = 1'b1;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DSLOT;
                    div_go  = 1'b1;
                end
            end
            S_DSLOT: begin
                if (div_done) begin
                    n_state = r_set ? S_SET : S_RD;
                end
            end
            S_SET: begin
                n_state = S_IDLE;
            end
            S_RD: begin
                n_state = S_BUMP;
            end
            S_BUMP: begin
                n_state = S_IDLE;
            end
            S_SUMRD: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = (r_cnt == CNT_W'(1)) ? S_OUT : S_SUMRD;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bin_sec  <= BSEC_W'(1);
            r_bins_use <= NBIN_W'(NUM_BINS);
            r_newest   <= '0;
            r_vld      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_BIN_SECONDS) begin
                    r_bin_sec <= i_cfg.data[BSEC_W-1:0];
                end else if (i_cfg.index == REG_BINS_IN_USE) begin
                    r_bins_use <= i_cfg.data[NBIN_W-1:0];
                end
            end
            if (r_state == S_CLEAR) begin
                r_vld[r_slot] <= 1'b0;
            end
            if (mem_we) begin
                r_vld[r_slot] <= 1'b1;
            end
            if (r_state == S_SET || (r_state == S_BUMP && r_upd)) begin
                r_newest <= r_t;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_cnt.valid && o_cnt.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (div_go) begin
            r_dq   <= div_a;
            r_rem  <= '0;
            r_dvs  <= div_b;
            r_dcnt <= '0;
        end else begin
            r_dq   <= q_nx;
            r_rem  <= rem_nx[BSEC_W-1:0];
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_kind <= i_evt.kind;
                    r_t    <= i_evt.time_s;
                    r_back <= i_evt.lookback_s;
                    r_sum  <= '0;
                end
            end
            S_DLAST: begin
                if (div_done) begin
                    r_last <= q_nx;
                end
            end
            S_DBIN: begin
                if (div_done) begin
                    r_bin <= q_nx;
                end
            end
            S_DIFF: begin
                r_diff <= {1'b0, r_last} - {1'b0, r_bin};
            end
            S_PLAN: begin
                r_set <= diff_borrow;
                r_upd <= diff_zero;
                if (r_kind == KIND_TICK) begin
                    r_cnt <= gap;
                end else begin
                    r_cnt <= CNT_W'(cnt_m1) + CNT_W'(1);
                end
            end
            S_DWALK, S_DSLOT: begin
                if (div_done) begin
                    r_slot <= rem_nx[SLOT_W-1:0];
                end
            end
            S_CLEAR, S_SUM: begin
                r_slot <= slot_nx;
                r_cnt  <= r_cnt - CNT_W'(1);
                if (r_state == S_SUM) begin
                    r_sum <= sum_sat;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    r_odata <= r_sum;
                end
            end
            default: begin
                r_slot <= r_slot;
            end
        endcase
    end

    // bin memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_slot] <= mem_wdata;
        end
        r_rd_data <= mem[r_slot];
        r_rd_vld  <= r_vld[r_slot];
    end

endmodule

### verif/berr_checker.sv
// scoreboard for the binned event rate recorder: mirrors the bin ring and checks each count beat
module berr_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_evt_valid,
    input  logic                            i_evt_ready,
    input  logic                            i_evt_kind,
    input  logic [berr_pkg::TIME_W-1:0]     i_evt_time_s,
    input  logic [berr_pkg::TIME_W-1:0]     i_evt_lookback_s,
    input  logic                            i_cnt_valid,
    input  logic                            i_cnt_ready,
    input  logic [berr_pkg::SUM_W-1:0]      i_cnt_tick_count,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [berr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [berr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import berr_pkg::*;

    localparam longint unsigned COUNT_SAT = (64'd1 << SUM_W) - 64'd1;

    logic [BIN_W-1:0]  bin_count [NUM_BINS];
    logic [TIME_W-1:0] latest_s;
    logic [BSEC_W-1:0] bin_width_reg;
    logic [NBIN_W-1:0] ring_len_reg;
    logic [SUM_W-1:0]  expected_counts [$];
    int                fails;

    function automatic longint unsigned width_eff();
        return (bin_width_reg == '0) ? 64'd1 : 64'(bin_width_reg);
    endfunction

    function automatic longint unsigned ring_eff();
        longint unsigned n;
        n = 64'(ring_len_reg);
        if (n < 2) n = 2;
        if (n > NUM_BINS) n = NUM_BINS;
        return n;
    endfunction

    function automatic void bump_bin(input longint unsigned slot);
        if (bin_count[slot] != '1) bin_count[slot] = bin_count[slot] + 1'b1;
    endfunction

    function automatic void record_tick(input logic [TIME_W-1:0] stamp);
        longint unsigned w, n, last_bin, bin, gap, k;
        w        = width_eff();
        n        = ring_eff();
        last_bin = 64'(latest_s) / w;
        bin      = 64'(stamp) / w;
        if (bin < last_bin) begin
            // late tick: kept only while its bin is still in the ring
            if (last_bin - bin < n) bump_bin(bin % n);
            return;
        end
        if (bin == last_bin) begin
            bump_bin(bin % n);
        end else begin
            gap = bin - last_bin - 1;
            if (gap > n) gap = n;
            for (k = 0; k < gap; k++) bin_count[(last_bin + 1 + k) % n] = '0;
            bin_count[bin % n] = BIN_W'(1);
        end
        latest_s = stamp;
    endfunction

    function automatic logic [SUM_W-1:0] window_count(input logic [TIME_W-1:0] now_s,
                                                     input logic [TIME_W-1:0] back_s);
        longint unsigned w, n, last_bin, back, first, lo, sum, i;
        w        = width_eff();
        n        = ring_eff();
        last_bin = 64'(latest_s) / w;
        back     = 64'(back_s);
        if (back > 64'(now_s)) back = 64'(now_s);
        first = (64'(now_s) - back) / w;
        lo    = (last_bin < n) ? 64'd0 : last_bin - (n - 1);
        if (first > lo) lo = first;
        sum = 0;
        if (lo <= last_bin) begin
            for (i = lo; i <= last_bin; i++) begin
                sum += 64'(bin_count[i % n]);
                if (sum > COUNT_SAT) sum = COUNT_SAT;
            end
        end
        return sum[SUM_W-1:0];
    endfunction

    always @(posedge i_clk) begin : score
        logic [SUM_W-1:0] want;
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_BINS; j++) bin_count[j] = '0;
            latest_s      = '0;
            bin_width_reg = BSEC_W'(1);
            ring_len_reg  = NBIN_W'(64);
            expected_counts.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_BIN_SECONDS: bin_width_reg = i_cfg_data[BSEC_W-1:0];
                    REG_BINS_IN_USE: ring_len_reg  = i_cfg_data[NBIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cnt_valid && i_cnt_ready) begin
                if (expected_counts.size() == 0) begin
                    $error("tick_count: expected none, actual %0d", i_cnt_tick_count);
                    fails++;
                end else begin
                    want = expected_counts.pop_front();
                    if (want !== i_cnt_tick_count) begin
                        $error("tick_count: expected %0d, actual %0d", want, i_cnt_tick_count);
                        fails++;
                    end
                end
            end
            if (i_evt_valid && i_evt_ready) begin
                if (i_evt_kind == KIND_TICK) begin
                    record_tick(i_evt_time_s);
                end else begin
                    expected_counts = {expected_counts,
                                       window_count(i_evt_time_s, i_evt_lookback_s)};
                end
            end
        end
        o_pending    <= expected_counts.size();
        o_fail_count <= fails;
    end

endmodule

### verif/binned_event_rate_recorder_core_tb.sv
// testbench top for the binned event rate recorder: drives ticks, queries and register writes
module binned_event_rate_recorder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import berr_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF;
    // indexes past the last register, written only to see them ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    logic i_clk = 1'b0;
    logic i_rst_n;

    berr_in_if  evt ();
    berr_out_if cnt ();
    berr_cfg_if cfg ();

    int fail_count;
    int pending_counts;
    int idle_cycles;
    int burst_left;

    // stimulus view of the ring: effective width, length and the newest tick time sent
    longint unsigned w_eff;
    longint unsigned n_eff;
    longint unsigned cursor;

    binned_event_rate_recorder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .o_cnt   (cnt),
        .i_cfg   (cfg)
    );

    berr_checker i_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_evt_valid      (evt.valid),
        .i_evt_ready      (evt.ready),
        .i_evt_kind       (evt.kind),
        .i_evt_time_s     (evt.time_s),
        .i_evt_lookback_s (evt.lookback_s),
        .i_cnt_valid      (cnt.valid),
        .i_cnt_ready      (cnt.ready),
        .i_cnt_tick_count (cnt.tick_count),
        .i_cfg_valid      (cfg.valid),
        .i_cfg_ready      (cfg.ready),
        .i_cfg_index      (cfg.index),
        .i_cfg_data       (cfg.data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_counts)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (evt.valid && evt.ready) || (cnt.valid && cnt.ready)
                || (cfg.valid && cfg.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // count sink: long ready runs, short and occasional long stalls
    initial begin : sink_pace
        int hold;
        int pick;
        hold = 0;
        cnt.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                cnt.ready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                pick = $urandom_range(99, 0);
                if (pick < 60) begin
                    cnt.ready <= 1'b1;
                    hold = $urandom_range(30, 0);
                end else if (pick < 90) begin
                    cnt.ready <= 1'b0;
                    hold = $urandom_range(3, 0);
                end else if (pick < 97) begin
                    cnt.ready <= 1'b0;
                    hold = $urandom_range(15, 4);
                end else begin
                    cnt.ready <= 1'b0;
                    hold = $urandom_range(60, 20);
                end
            end
        end
    end

    function automatic int pick_gap();
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(99, 0);
        if (pick < 5) begin
            burst_left = $urandom_range(40, 10);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(3, 1);
        if (pick < 96) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic push_event(input logic kind, input logic [TIME_W-1:0] stamp,
                              input logic [TIME_W-1:0] back);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            evt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt.valid      <= 1'b1;
        evt.kind       <= kind;
        evt.time_s     <= stamp;
        evt.lookback_s <= back;
        @(posedge i_clk);
        while (!evt.ready) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] width_val,
                              input logic [CFG_DATA_W-1:0] ring_val, input bit spare);
        longint unsigned n;
        cfg_beat(REG_BIN_SECONDS, width_val);
        cfg_beat(REG_BINS_IN_USE, ring_val);
        if (spare) begin
            cfg_beat(REG_SPARE_2, CFG_DATA_W'($urandom()));
            cfg_beat(REG_SPARE_3, CFG_DATA_W'($urandom()));
        end
        cfg.valid <= 1'b0;
        w_eff = (width_val == '0) ? 64'd1 : 64'(width_val);
        n = 64'(ring_val[NBIN_W-1:0]);
        if (n < 2) n = 2;
        if (n > NUM_BINS) n = NUM_BINS;
        n_eff = n;
    endtask

    // all beats in, all counts out, then let a last tick finish inside the block
    task automatic drain_and_settle();
        evt.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random time inside the bin delta bins away from the newest tick sent
    function automatic logic [TIME_W-1:0] stamp_at(input longint delta);
        longint          b;
        longint unsigned t;
        b = longint'(cursor / w_eff) + delta;
        if (b < 0) b = 0;
        t = unsigned'(b) * w_eff + 64'($urandom_range(32'(w_eff - 1), 0));
        if (t > TIME_MAX) t = TIME_MAX;
        return t[TIME_W-1:0];
    endfunction

    task automatic run_random(input int count);
        int              pick;
        int              n;
        longint unsigned t;
        logic [TIME_W-1:0] back;
        n = int'(n_eff);
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if ($urandom_range(99, 0) < 65) begin
                if (pick < 35) t = stamp_at(0);
                else if (pick < 65) t = stamp_at($urandom_range(3, 1));
                else if (pick < 80) t = stamp_at(-longint'($urandom_range(n + 1, 1)));
                else if (pick < 92) t = stamp_at($urandom_range(n + 3, n - 2));
                else if (pick < 97) t = stamp_at($urandom_range(n, 4));
                else t = 64'($urandom_range(32'(cursor), 0));
                if (t > cursor) cursor = t;
                push_event(KIND_TICK, t[TIME_W-1:0], $urandom());
            end else begin
                if (pick < 70) t = cursor + 64'($urandom_range(32'(3 * w_eff), 0));
                else if (pick < 85) t = 64'($urandom_range(32'(cursor), 0));
                else t = 64'($urandom());
                if (t > TIME_MAX) t = TIME_MAX;
                pick = $urandom_range(99, 0);
                if (pick < 10) back = '0;
                else if (pick < 70) back = $urandom_range(32'((n_eff + 4) * w_eff), 0);
                else if (pick < 85) back = $urandom();
                else if (pick < 90) back = t[TIME_W-1:0];
                else back = $urandom_range(32'(w_eff), 0);
                push_event(KIND_QUERY, t[TIME_W-1:0], back);
            end
        end
    endtask

    initial begin : stimulus
        longint unsigned b;
        i_rst_n        <= 1'b0;
        evt.valid      <= 1'b0;
        evt.kind       <= KIND_TICK;
        evt.time_s     <= '0;
        evt.lookback_s <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= REG_BIN_SECONDS;
        cfg.data       <= '0;
        burst_left = 0;
        w_eff  = 1;
        n_eff  = NUM_BINS;
        cursor = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one-second bins, full ring
        push_event(KIND_QUERY, 32'd0, 32'd0);
        push_event(KIND_TICK, 32'd0, 32'hFFFF_FFFF);
        push_event(KIND_TICK, 32'd0, 32'd0);
        push_event(KIND_QUERY, 32'd0, 32'd0);
        push_event(KIND_TICK, 32'd5, 32'd0);
        push_event(KIND_TICK, 32'd3, 32'd0);
        push_event(KIND_QUERY, 32'd5, 32'd5);
        push_event(KIND_TICK, 32'd200, 32'd0);     // skip wider than the ring
        push_event(KIND_TICK, 32'd100, 32'd0);     // far too old
        push_event(KIND_TICK, 32'd137, 32'd0);     // last bin still in the ring
        push_event(KIND_TICK, 32'd136, 32'd0);     // one bin past the ring
        push_event(KIND_QUERY, 32'd200, 32'hFFFF_FFFF);
        push_event(KIND_QUERY, 32'd300, 32'd10);   // window opens after newest bin
        push_event(KIND_QUERY, 32'd199, 32'd0);
        push_event(KIND_TICK, 32'd263, 32'd0);
        push_event(KIND_QUERY, 32'd263, 32'd100);
        cursor = 263;
        run_random(220);

        drain_and_settle();
        write_regs(16'd0, 16'd1, 1'b0);            // zero width and too short a ring
        run_random(180);

        drain_and_settle();
        write_regs(16'hFFFF, 16'd64, 1'b0);
        run_random(200);

        drain_and_settle();
        write_regs(16'd7, 16'd2, 1'b1);
        b = cursor / w_eff + 3;
        push_event(KIND_TICK, 32'(b * 7 + 6), 32'd0);
        push_event(KIND_TICK, 32'(b * 7 + 1), 32'd0);    // earlier inside the newest bin
        push_event(KIND_TICK, 32'(b * 7 - 14), 32'd0);   // two bins back, out of a 2-bin ring
        push_event(KIND_TICK, 32'(b * 7 - 7), 32'd0);
        push_event(KIND_QUERY, 32'(b * 7 + 6), 32'd0);
        push_event(KIND_QUERY, 32'(b * 7 + 6), 32'd7);
        cursor = b * 7 + 6;
        run_random(180);

        drain_and_settle();
        write_regs(16'd3, 16'hFFE4, 1'b0);         // ring length above the bin count
        run_random(200);

        drain_and_settle();
        write_regs(CFG_DATA_W'($urandom_range(65535, 1)), CFG_DATA_W'($urandom()), 1'b1);
        run_random(200);

        drain_and_settle();
        write_regs(16'd2, 16'h0F80, 1'b0);
        run_random(120);

        // top of the time range last, since the newest time cannot come back down
        drain_and_settle();
        write_regs(16'd1, 16'd64, 1'b0);
        push_event(KIND_TICK, 32'hFFFF_FFFF, 32'd0);
        push_event(KIND_TICK, 32'hFFFF_FFFE, 32'd0);
        push_event(KIND_TICK, 32'hFFFF_FFC0, 32'd0);
        push_event(KIND_TICK, 32'hFFFF_FFBF, 32'd0);
        push_event(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_event(KIND_QUERY, 32'hFFFF_FFFF, 32'd0);
        push_event(KIND_QUERY, 32'hFFFF_FFFF, 32'd10);
        cursor = TIME_MAX;
        run_random(150);

        drain_and_settle();
        if (fail_count == 0 && pending_counts == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
